>>> rtl/core/wprf_pkg.sv
// Shared types and constants of the waveform peak region finder.
// Holds the command record passed from the front end to the back end.
// No dependencies.
`default_nettype none

package wprf_pkg;

  localparam int IDX_W       = 12;  // width of every index field on the result port
  localparam int THR_W       = 16;  // width of the threshold registers
  localparam int MAX_RESULTS = 8;   // results one sample may cause
  localparam int FL_W        = 4;   // holds 0 .. MAX_RESULTS
  localparam int CQ_DEPTH    = 4;   // command queue entries
  localparam int CQ_PTR_W    = 2;
  localparam int CQ_CNT_W    = 3;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_THR_IND = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_THR_COL = 1'b1;

  // One command per sample that touches the pending queue or ends the wire.
  typedef struct packed {
    logic            push;       // queue a new peak
    logic            emit;       // close the oldest peak at end_idx
    logic            last_item;  // final sample: flush and clear
    logic            ovf;        // overflow flag of the wire after this sample
    logic [FL_W-1:0] flush_n;    // entries to flush
    logic [IDX_W-1:0] start_idx;
    logic [IDX_W-1:0] peak_idx;
    logic [IDX_W-1:0] end_idx;
    logic [IDX_W-1:0] last_idx;
  } cmd_t;

endpackage

`default_nettype wire

>>> rtl/core/wprf_front.sv
// Front end: sample history, window classification and queue bookkeeping.
// Turns each accepted sample into at most one command. Uses wprf_pkg.
`default_nettype none

module wprf_front
  import wprf_pkg::*;
#(
  parameter int MAX_SAMPLES   = 4096,
  parameter int PENDING_DEPTH = 8,
  parameter int SAMPLE_BITS   = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  input  wire logic                          cq_full,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_value,
  input  wire logic                          plane_kind,
  input  wire logic                          final_sample,
  input  wire logic signed [THR_W-1:0]       thr_ind,
  input  wire logic signed [THR_W-1:0]       thr_col,
  output logic                               cmd_wr,
  output cmd_t                               cmd_ctl,
  output logic signed [SAMPLE_BITS-1:0]      cmd_height
);

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int QC_W  = $clog2(PENDING_DEPTH + 1);
  localparam int CMP_W = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;
  localparam int LIM_W = (QC_W > FL_W) ? QC_W : FL_W;

  logic signed [SAMPLE_BITS-1:0] older, older_next;
  logic signed [SAMPLE_BITS-1:0] newer, newer_next;
  logic [CNT_W-1:0]              counter, counter_next;
  logic                          peak_open, peak_open_next;
  logic [IDX_W-1:0]              start_hold, start_hold_next;
  logic [QC_W-1:0]               pend_cnt, pend_cnt_next;
  logic                          ovf_seen, ovf_seen_next;

  logic                    accept, active, window, is_min, is_max;
  logic                    do_push, do_emit;
  logic signed [CMP_W-1:0] newer_x, thr_x;
  logic [IDX_W-1:0]        idx12, ctr12, last12;
  logic [QC_W-1:0]         cnt_after;
  logic [FL_W-1:0]         limit, flush_n;

  assign accept = in_valid && !cq_full;
  assign active = (counter != CNT_W'(MAX_SAMPLES));
  assign window = active && (counter >= CNT_W'(2));

  assign newer_x = CMP_W'(newer);
  assign thr_x   = plane_kind ? CMP_W'(thr_col) : CMP_W'(thr_ind);

  assign is_min = (older > newer) && (newer < sample_value);
  assign is_max = (older < newer) && (newer > sample_value) && (newer_x > thr_x);

  assign idx12  = IDX_W'(counter);
  assign ctr12  = idx12 - IDX_W'(1);
  assign last12 = active ? idx12 : IDX_W'(MAX_SAMPLES - 1);

  assign do_emit = window && is_min && peak_open && (pend_cnt != '0);
  assign do_push = window && !is_min && is_max && (pend_cnt < QC_W'(PENDING_DEPTH));

  assign cnt_after = pend_cnt + QC_W'(do_push) - QC_W'(do_emit);
  assign limit     = do_emit ? FL_W'(MAX_RESULTS - 1) : FL_W'(MAX_RESULTS);

  always_comb begin
    if (!final_sample) begin
      flush_n = '0;
    end else if (LIM_W'(cnt_after) < LIM_W'(limit)) begin
      flush_n = FL_W'(cnt_after);
    end else begin
      flush_n = limit;
    end
  end

  always_comb begin
    older_next      = older;
    newer_next      = newer;
    counter_next    = counter;
    peak_open_next  = peak_open;
    start_hold_next = start_hold;
    pend_cnt_next   = pend_cnt;
    ovf_seen_next   = ovf_seen;
    if (accept) begin
      if (window && is_min) begin
        peak_open_next  = 1'b0;
        start_hold_next = peak_open ? idx12 : ctr12;
      end else if (window && is_max) begin
        peak_open_next = 1'b1;
        if (!do_push) begin
          ovf_seen_next = 1'b1;
        end
      end
      pend_cnt_next = cnt_after;
      if (active) begin
        older_next   = newer;
        newer_next   = sample_value;
        counter_next = counter + CNT_W'(1);
      end
      // end of wire: drop all per-wire state
      if (final_sample) begin
        older_next      = '0;
        newer_next      = '0;
        counter_next    = '0;
        peak_open_next  = 1'b0;
        start_hold_next = '0;
        pend_cnt_next   = '0;
        ovf_seen_next   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      older      <= '0;
      newer      <= '0;
      counter    <= '0;
      peak_open  <= 1'b0;
      start_hold <= '0;
      pend_cnt   <= '0;
      ovf_seen   <= 1'b0;
    end else begin
      older      <= older_next;
      newer      <= newer_next;
      counter    <= counter_next;
      peak_open  <= peak_open_next;
      start_hold <= start_hold_next;
      pend_cnt   <= pend_cnt_next;
      ovf_seen   <= ovf_seen_next;
    end
  end

  assign cmd_wr = accept && (do_push || do_emit || final_sample);

  always_comb begin
    cmd_ctl.push      = do_push;
    cmd_ctl.emit      = do_emit;
    cmd_ctl.last_item = final_sample;
    cmd_ctl.ovf       = ovf_seen || (window && !is_min && is_max && !do_push);
    cmd_ctl.flush_n   = flush_n;
    cmd_ctl.start_idx = start_hold;
    cmd_ctl.peak_idx  = ctr12;
    cmd_ctl.end_idx   = ctr12;
    cmd_ctl.last_idx  = last12;
  end

  assign cmd_height = newer;

endmodule

`default_nettype wire

>>> rtl/core/wprf_cmdq.sv
// Short command queue between front end and back end.
// Flip-flop FIFO of CQ_DEPTH entries. Uses wprf_pkg.
`default_nettype none

module wprf_cmdq
  import wprf_pkg::*;
#(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         wr_en,
  input  wire logic [W-1:0] wr_data,
  output logic              full,
  input  wire logic         rd_en,
  output logic              rd_valid,
  output logic [W-1:0]      rd_data
);

  logic [W-1:0]        slots [CQ_DEPTH];
  logic [CQ_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CQ_CNT_W-1:0] count;
  logic                do_wr, do_rd;

  assign full     = (count == CQ_CNT_W'(CQ_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = slots[rd_ptr];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + CQ_PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + CQ_PTR_W'(1);
      end
      count <= count + CQ_CNT_W'(do_wr) - CQ_CNT_W'(do_rd);
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/wprf_back.sv
// Back end: pending-peak memory, emit and flush sequencing, result register.
// Executes commands from wprf_cmdq. Uses wprf_pkg.
`default_nettype none

module wprf_back
  import wprf_pkg::*;
#(
  parameter int PENDING_DEPTH = 8,
  parameter int SAMPLE_BITS   = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cmd_valid,
  input  wire cmd_t                          cmd_ctl,
  input  wire logic signed [SAMPLE_BITS-1:0] cmd_height,
  output logic                               cmd_pop,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [IDX_W-1:0]                   start_index,
  output logic [IDX_W-1:0]                   peak_index,
  output logic [IDX_W-1:0]                   end_index,
  output logic signed [SAMPLE_BITS-1:0]      peak_height,
  output logic                               maxima_dropped,
  output logic                               wire_done
);

  localparam int PTR_W = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;

  typedef enum logic [1:0] {
    PH_CMD   = 2'b01,
    PH_FLUSH = 2'b10
  } phase_t;

  logic [IDX_W-1:0]              mem_start  [PENDING_DEPTH];
  logic [IDX_W-1:0]              mem_peak   [PENDING_DEPTH];
  logic signed [SAMPLE_BITS-1:0] mem_height [PENDING_DEPTH];

  logic [IDX_W-1:0]              rd_start, rd_peak;
  logic signed [SAMPLE_BITS-1:0] rd_height;

  phase_t          phase, phase_next;
  logic [PTR_W-1:0] head, head_next, tail, tail_next;
  logic [FL_W-1:0]  flush_left, flush_left_next;

  logic             out_free, we, adv, clr, load;
  logic [IDX_W-1:0] load_end;
  logic             load_done;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(PENDING_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign out_free = !out_valid || !out_stall;

  always_comb begin
    phase_next      = phase;
    flush_left_next = flush_left;
    we              = 1'b0;
    adv             = 1'b0;
    clr             = 1'b0;
    load            = 1'b0;
    load_end        = cmd_ctl.end_idx;
    load_done       = 1'b0;
    cmd_pop         = 1'b0;
    unique case (phase)
      PH_CMD: begin
        // an emit needs the result register; push and flush setup do not
        if (cmd_valid && (!cmd_ctl.emit || out_free)) begin
          we = cmd_ctl.push;
          if (cmd_ctl.emit) begin
            load      = 1'b1;
            adv       = 1'b1;
            load_done = cmd_ctl.last_item && (cmd_ctl.flush_n == '0);
          end
          if (cmd_ctl.flush_n != '0) begin
            phase_next      = PH_FLUSH;
            flush_left_next = cmd_ctl.flush_n;
          end else begin
            cmd_pop = 1'b1;
            clr     = cmd_ctl.last_item;
          end
        end
      end
      PH_FLUSH: begin
        if (out_free) begin
          load            = 1'b1;
          adv             = 1'b1;
          load_end        = cmd_ctl.last_idx;
          load_done       = (flush_left == FL_W'(1));
          flush_left_next = flush_left - FL_W'(1);
          if (flush_left == FL_W'(1)) begin
            phase_next = PH_CMD;
            cmd_pop    = 1'b1;
            clr        = 1'b1;
          end
        end
      end
      default: begin
        phase_next = PH_CMD;
      end
    endcase
  end

  always_comb begin
    if (clr) begin
      head_next = '0;
      tail_next = '0;
    end else begin
      head_next = adv ? ptr_inc(head) : head;
      tail_next = we ? ptr_inc(tail) : tail;
    end
  end

  // keep the head entry in the read register; forward a write to the same slot
  always_ff @(posedge clk) begin
    if (we) begin
      mem_start[tail]  <= cmd_ctl.start_idx;
      mem_peak[tail]   <= cmd_ctl.peak_idx;
      mem_height[tail] <= cmd_height;
    end
    if (we && (tail == head_next)) begin
      rd_start  <= cmd_ctl.start_idx;
      rd_peak   <= cmd_ctl.peak_idx;
      rd_height <= cmd_height;
    end else begin
      rd_start  <= mem_start[head_next];
      rd_peak   <= mem_peak[head_next];
      rd_height <= mem_height[head_next];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_CMD;
      head       <= '0;
      tail       <= '0;
      flush_left <= '0;
      out_valid  <= 1'b0;
    end else begin
      phase      <= phase_next;
      head       <= head_next;
      tail       <= tail_next;
      flush_left <= flush_left_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      start_index    <= rd_start;
      peak_index     <= rd_peak;
      end_index      <= load_end;
      peak_height    <= rd_height;
      maxima_dropped <= cmd_ctl.ovf;
      wire_done      <= load_done;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/waveform_peak_region_finder_core.sv
// Waveform peak region finder: one wire's samples in, hit regions out.
// Holds the threshold registers and joins front end, command queue and back end.
// Uses wprf_pkg, wprf_front, wprf_cmdq, wprf_back.
//
// Samples enter on in_valid/in_stall, one per cycle while in_stall is low, in
// index order, with the plane kind and a flag on the wire's last sample. Each
// strict local maximum above the plane's threshold opens a pending peak if one
// is free; each strict local minimum after a maximum closes the oldest pending
// peak and sends one hit out on out_valid/out_stall. The last sample flushes
// the pending peaks, up to MAX_RESULTS hits, one hit per cycle while out_stall
// is low, the final one carrying wire_done, and starts a fresh wire. Thresholds
// are written on cfg_valid/cfg_ready (always ready); the user writes them only
// while idle, which the block itself does not enforce. A minimum's command
// passes the command queue before the back end registers its hit. A flush
// holds the back end while it takes the command and sends its hits; the
// four-entry command queue absorbs samples and in_stall rises only once it is
// full. A hit held by out_stall stops emits and flushes. Reset clears
// thresholds, history and queues; no result is lost or repeated across a stall.
`default_nettype none

module waveform_peak_region_finder_core
  import wprf_pkg::*;
#(
  parameter int MAX_SAMPLES   = 4096,
  parameter int PENDING_DEPTH = 8,
  parameter int SAMPLE_BITS   = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_value,
  input  wire logic                          plane_kind,
  input  wire logic                          final_sample,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [IDX_W-1:0]                   start_index,
  output logic [IDX_W-1:0]                   peak_index,
  output logic [IDX_W-1:0]                   end_index,
  output logic signed [SAMPLE_BITS-1:0]      peak_height,
  output logic                               maxima_dropped,
  output logic                               wire_done,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [THR_W-1:0]              cfg_data
);

  localparam int CQ_W = $bits(cmd_t) + SAMPLE_BITS;

  logic signed [THR_W-1:0] thr_ind, thr_col;

  logic                          cq_full, cmd_wr, q_valid, q_pop;
  cmd_t                          wr_ctl, q_ctl;
  logic signed [SAMPLE_BITS-1:0] wr_height, q_height;
  logic [CQ_W-1:0]               q_data;

  assign cfg_ready = 1'b1;
  assign in_stall  = cq_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr_ind <= '0;
      thr_col <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_THR_IND: thr_ind <= cfg_data;
        CFG_THR_COL: thr_col <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  wprf_front #(
    .MAX_SAMPLES  (MAX_SAMPLES),
    .PENDING_DEPTH(PENDING_DEPTH),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .cq_full     (cq_full),
    .sample_value(sample_value),
    .plane_kind  (plane_kind),
    .final_sample(final_sample),
    .thr_ind     (thr_ind),
    .thr_col     (thr_col),
    .cmd_wr      (cmd_wr),
    .cmd_ctl     (wr_ctl),
    .cmd_height  (wr_height)
  );

  wprf_cmdq #(
    .W(CQ_W)
  ) u_cmdq (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_wr),
    .wr_data ({wr_ctl, wr_height}),
    .full    (cq_full),
    .rd_en   (q_pop),
    .rd_valid(q_valid),
    .rd_data (q_data)
  );

  assign q_ctl    = q_data[CQ_W-1:SAMPLE_BITS];
  assign q_height = q_data[SAMPLE_BITS-1:0];

  wprf_back #(
    .PENDING_DEPTH(PENDING_DEPTH),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (q_valid),
    .cmd_ctl       (q_ctl),
    .cmd_height    (q_height),
    .cmd_pop       (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .start_index   (start_index),
    .peak_index    (peak_index),
    .end_index     (end_index),
    .peak_height   (peak_height),
    .maxima_dropped(maxima_dropped),
    .wire_done     (wire_done)
  );

endmodule

`default_nettype wire

>>> sim/tb_waveform_peak_region_finder_core.sv
// Testbench for waveform_peak_region_finder_core: streams wires of samples, predicts
// every hit region and checks the result port item by item, with random idling on both sides.
// Depends on wprf_pkg and the core RTL.
module tb_waveform_peak_region_finder_core;
  import wprf_pkg::*;

  localparam int MAX_SAMPLES   = 4096;
  localparam int PENDING_DEPTH = 8;
  localparam int SAMPLE_BITS   = 16;
  localparam int DRAIN_CYCLES  = 24;
  localparam int STALL_LIMIT   = 4000;
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    logic [IDX_W-1:0]              start_idx;
    logic [IDX_W-1:0]              peak_idx;
    logic [IDX_W-1:0]              end_idx;
    logic signed [SAMPLE_BITS-1:0] height;
    logic                          dropped;
    logic                          done;
  } hit_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] value;
    logic                          plane;
    logic                          last;
  } sample_t;

  typedef struct packed {
    sample_t item;
    logic    typed;
    hit_t    hit;
  } dir_row_t;

  localparam hit_t NO_HIT = '0;
  localparam int DIR_ROWS = 22;

  // Rows with typed set carry the one hit that sample must produce.
  localparam dir_row_t DIR_TABLE [0:DIR_ROWS-1] = '{
    // induction wire: extremes, a closed peak, two peaks over a flat valley, flush
    '{'{16'sd0,      1'b0, 1'b0}, 1'b0, NO_HIT},
    '{'{16'sh7fff,   1'b0, 1'b0}, 1'b0, NO_HIT},
    '{'{16'sh8000,   1'b0, 1'b0}, 1'b0, NO_HIT},
    '{'{16'sd5,      1'b0, 1'b0}, 1'b1, '{12'd0, 12'd1, 12'd2, 16'sh7fff, 1'b0, 1'b0}},
    '{'{16'sd10,     1'b0, 1'b0}, 1'b0, NO_HIT},
    '{'{16'sd3,      1'b0, 1'b0}, 1'b0, NO_HIT},
    '{'{16'sd3,      1'b0, 1'b0}, 1'b0, NO_HIT},
    '{'{16'sd8,      1'b0, 1'b0}, 1'b0, NO_HIT},
    '{'{16'sd1,      1'b0, 1'b0}, 1'b0, NO_HIT},
    '{'{-16'sd1,     1'b0, 1'b1}, 1'b0, NO_HIT},
    // collection wire: one peak flushed by the last sample
    '{'{-16'sd5,     1'b1, 1'b0}, 1'b0, NO_HIT},
    '{'{16'sd40,     1'b1, 1'b0}, 1'b0, NO_HIT},
    '{'{-16'sd9,     1'b1, 1'b0}, 1'b0, NO_HIT},
    '{'{-16'sd9,     1'b1, 1'b1}, 1'b1, '{12'd0, 12'd1, 12'd3, 16'sd40, 1'b0, 1'b1}},
    // maximum below threshold, then a minimum with nothing queued
    '{'{-16'sd5,     1'b1, 1'b0}, 1'b0, NO_HIT},
    '{'{-16'sd2,     1'b1, 1'b0}, 1'b0, NO_HIT},
    '{'{-16'sd9,     1'b1, 1'b0}, 1'b0, NO_HIT},
    '{'{-16'sd3,     1'b1, 1'b0}, 1'b0, NO_HIT},
    '{'{16'sd0,      1'b1, 1'b1}, 1'b0, NO_HIT},
    // wires too short to form a window
    '{'{16'sd7,      1'b0, 1'b1}, 1'b0, NO_HIT},
    '{'{16'sd1,      1'b1, 1'b0}, 1'b0, NO_HIT},
    '{'{16'sd9,      1'b1, 1'b1}, 1'b0, NO_HIT}
  };

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic signed [SAMPLE_BITS-1:0] sample_value = '0;
  logic                          plane_kind = 1'b0;
  logic                          final_sample = 1'b0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [IDX_W-1:0]              start_index;
  logic [IDX_W-1:0]              peak_index;
  logic [IDX_W-1:0]              end_index;
  logic signed [SAMPLE_BITS-1:0] peak_height;
  logic                          maxima_dropped;
  logic                          wire_done;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [CFG_IDX_W-1:0]          cfg_index = CFG_THR_IND;
  logic [THR_W-1:0]              cfg_data = '0;

  // predictor state, reset values as after rst
  logic signed [THR_W-1:0]       thr_ind = '0;
  logic signed [THR_W-1:0]       thr_col = '0;
  logic signed [SAMPLE_BITS-1:0] hist_old = '0;
  logic signed [SAMPLE_BITS-1:0] hist_new = '0;
  int                            sample_cnt = 0;
  bit                            peak_seen = 1'b0;
  int                            start_mark = 0;
  bit                            ovf_seen = 1'b0;
  hit_t                          open_peaks[$];
  hit_t                          sample_hits[$];
  hit_t                          expected_hits[$];

  sample_t wire_samples[$];
  int      mismatch_count = 0;
  int      idle_cycles = 0;
  int      rx_hold = 0;
  bit      tx_gaps = 1'b1;
  bit      rx_gaps = 1'b1;

  waveform_peak_region_finder_core #(
    .MAX_SAMPLES  (MAX_SAMPLES),
    .PENDING_DEPTH(PENDING_DEPTH),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .sample_value  (sample_value),
    .plane_kind    (plane_kind),
    .final_sample  (final_sample),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .start_index   (start_index),
    .peak_index    (peak_index),
    .end_index     (end_index),
    .peak_height   (peak_height),
    .maxima_dropped(maxima_dropped),
    .wire_done     (wire_done),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Advance the hit predictor by one accepted sample; leaves its hits in sample_hits.
  function automatic void predict_hits(sample_t it);
    logic signed [SAMPLE_BITS-1:0] s;
    logic signed [THR_W-1:0]       thr;
    int                            c;
    int                            last_i;
    hit_t                          h;
    s = it.value;
    thr = it.plane ? thr_col : thr_ind;
    sample_hits.delete();
    if (sample_cnt < MAX_SAMPLES) begin
      if (sample_cnt >= 2) begin
        c = sample_cnt - 1;
        if (hist_old > hist_new && hist_new < s) begin
          if (peak_seen) begin
            if (open_peaks.size() > 0) begin
              h = open_peaks.pop_front();
              h.end_idx = IDX_W'(c);
              h.dropped = ovf_seen;
              sample_hits = {sample_hits, h};
            end
            peak_seen = 1'b0;
            start_mark = sample_cnt;
          end else begin
            start_mark = c;
          end
        end else if (hist_old < hist_new && hist_new > s && hist_new > thr) begin
          peak_seen = 1'b1;
          if (open_peaks.size() < PENDING_DEPTH) begin
            h = NO_HIT;
            h.start_idx = IDX_W'(start_mark);
            h.peak_idx = IDX_W'(c);
            h.height = hist_new;
            open_peaks = {open_peaks, h};
          end else begin
            ovf_seen = 1'b1;
          end
        end
      end
      hist_old = hist_new;
      hist_new = s;
      last_i = sample_cnt;
      sample_cnt++;
    end else begin
      last_i = MAX_SAMPLES - 1;
    end
    if (it.last) begin
      foreach (open_peaks[i]) begin
        if (sample_hits.size() < MAX_RESULTS) begin
          h = open_peaks[i];
          h.end_idx = IDX_W'(last_i);
          h.dropped = ovf_seen;
          sample_hits = {sample_hits, h};
        end
      end
      if (sample_hits.size() > 0) sample_hits[sample_hits.size() - 1].done = 1'b1;
      hist_old = '0;
      hist_new = '0;
      sample_cnt = 0;
      peak_seen = 1'b0;
      start_mark = 0;
      open_peaks.delete();
      ovf_seen = 1'b0;
    end
  endfunction

  function automatic void report_mismatch(string what, hit_t want, hit_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%0t %s: expected start %0d peak %0d end %0d height %0d dropped %0b done %0b",
               $time, what, want.start_idx, want.peak_idx, want.end_idx, want.height,
               want.dropped, want.done);
    if (mismatch_count <= MAX_REPORTS)
      $display("%0t %s:      got start %0d peak %0d end %0d height %0d dropped %0b done %0b",
               $time, what, got.start_idx, got.peak_idx, got.end_idx, got.height,
               got.dropped, got.done);
  endfunction

  // Build one wire: noise, a comb of peaks over flat valleys, or a random walk.
  function automatic void build_wire(int forced_len);
    int       len;
    int       style;
    int       amp;
    int       v;
    int       a;
    int       dir;
    int       plateau_pct;
    bit [31:0] w;
    sample_t  s;
    style = $urandom_range(0, 9);
    case ($urandom_range(0, 9))
      0: len = $urandom_range(1, 2);
      1, 2, 3: len = $urandom_range(3, 12);
      default: len = $urandom_range(13, 50);
    endcase
    if (style == 2 || style == 3) len = $urandom_range(20, 45);
    if (forced_len > 0) len = forced_len;
    case ($urandom_range(0, 2))
      0: amp = 4;
      1: amp = 300;
      default: amp = 20000;
    endcase
    plateau_pct = $urandom_range(0, 50);
    v = int'($urandom_range(0, 4000)) - 2000;
    a = v;
    dir = 1;
    s.plane = 1'($urandom_range(0, 1));
    wire_samples.delete();
    for (int i = 0; i < len; i++) begin
      if (style < 2) begin
        w = $urandom();
        v = $signed(w[15:0]);
      end else if (style < 4) begin
        // peaks separated by flat valleys pile up in the queue; a rare dip closes one
        if (i % 3 == 1) v = a + int'($urandom_range(1, 3000));
        else if (i % 3 == 2 && $urandom_range(0, 7) == 0) v = a - int'($urandom_range(1, 100));
        else v = a;
      end else begin
        if ($urandom_range(0, 2) == 0) dir = -dir;
        if (int'($urandom_range(1, 100)) > plateau_pct) v = v + dir * int'($urandom_range(1, amp));
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
      end
      s.value = v[15:0];
      s.last = (i == len - 1);
      wire_samples = {wire_samples, s};
    end
  endfunction

  // Present one sample at the falling edge and hold it until accepted.
  task automatic send_sample(sample_t it, logic typed, hit_t typed_hit);
    if (tx_gaps && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_valid <= 1'b1;
    sample_value <= it.value;
    plane_kind <= it.plane;
    final_sample <= it.last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_hits(it);
    if (typed) expected_hits = {expected_hits, typed_hit};
    else expected_hits = {expected_hits, sample_hits};
    @(negedge clk);
  endtask

  task automatic run_wires(int items, int forced_len);
    int sent;
    sent = 0;
    while (sent < items) begin
      build_wire(forced_len);
      foreach (wire_samples[i]) send_sample(wire_samples[i], 1'b0, NO_HIT);
      sent += wire_samples.size();
    end
    in_valid <= 1'b0;
  endtask

  task automatic set_thresholds(logic signed [THR_W-1:0] ind, logic signed [THR_W-1:0] col);
    for (int r = 0; r < 2; r++) begin
      cfg_valid <= 1'b1;
      cfg_index <= (r == 0) ? CFG_THR_IND : CFG_THR_COL;
      cfg_data <= (r == 0) ? ind : col;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      if (r == 0) thr_ind = ind;
      else thr_col = col;
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // Wait for every expected hit, then let a flush that causes nothing finish.
  task automatic wait_idle();
    while (expected_hits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (rx_hold > 0) rx_hold--;
    else if (rx_gaps && $urandom_range(0, 9) == 0) rx_hold = $urandom_range(1, 17);
    out_stall <= (rx_hold > 0);
  end

  always @(posedge clk) begin : check_hit
    hit_t got;
    hit_t want;
    if (!rst && out_valid && !out_stall) begin
      got = '{start_index, peak_index, end_index, peak_height, maxima_dropped, wire_done};
      if (expected_hits.size() == 0) begin
        report_mismatch("unexpected hit", NO_HIT, got);
      end else begin
        want = expected_hits.pop_front();
        if (got !== want) report_mismatch("hit mismatch", want, got);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("waveform_peak_region_finder_core test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed rows run on the reset thresholds
    foreach (DIR_TABLE[r]) send_sample(DIR_TABLE[r].item, DIR_TABLE[r].typed, DIR_TABLE[r].hit);
    in_valid <= 1'b0;
    wait_idle();

    set_thresholds(16'sh8000, 16'sh7fff);
    run_wires(50, 0);
    wait_idle();

    set_thresholds(16'sh7fff, 16'sh8000);
    run_wires(50, 0);
    wait_idle();

    repeat (3) begin
      set_thresholds(THR_W'(int'($urandom_range(0, 3000)) - 1500),
                     THR_W'(int'($urandom_range(0, 3000)) - 1500));
      run_wires(50, 0);
      wait_idle();
    end

    // drop all idling for the closing stretch
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    set_thresholds(THR_W'(int'($urandom_range(0, 3000)) - 1500),
                   THR_W'(int'($urandom_range(0, 3000)) - 1500));
    run_wires(60, 0);
    wait_idle();

    if (mismatch_count == 0) begin
      $display("waveform_peak_region_finder_core test passed");
    end else begin
      $display("waveform_peak_region_finder_core test failed");
    end
    $finish;
  end

endmodule
